// ===== design/itrd_pkg.sv =====
// Shared types, constants and helpers for the integer to radix digits block.
// No dependencies; imported by the divider, the RAM users and the top level.
package itrd_pkg;

    localparam int VALUE_W       = 32;  // width of the input value field
    localparam int RADIX_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int STORE_DEPTH   = 32;
    localparam int ADDR_W        = 5;
    localparam int COUNT_W       = 6;
    localparam int DIV_STEP_BITS = 4;   // quotient bits resolved per divider cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_LIMIT   = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_A      = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_TEN    = 7'd10;

    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [RADIX_W-1:0] remainder;
    } t_div_rsp;

    function automatic logic [RADIX_W-1:0] radix_sat(input logic [RADIX_W-1:0] v);
        logic [RADIX_W-1:0] r;
        r = v;
        if (v < RADIX_MIN) r = RADIX_MIN;
        if (v > RADIX_MAX) r = RADIX_MAX;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DEC_LIMIT) begin
            c = ({1'b0, d} - CHAR_TEN) + CHAR_A;
        end else begin
            c = {1'b0, d} + CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

// ===== design/itrd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module itrd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/itrd_divider.sv =====
// Iterative restoring divider: unsigned dividend by a 6-bit divisor,
// DIV_STEP_BITS quotient bits per cycle. Depends on itrd_pkg.
module itrd_divider #(
    parameter int DIVIDEND_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  itrd_pkg::t_div_req       i_req,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    output itrd_pkg::t_div_rsp       o_rsp,
    output logic [DIVIDEND_BITS-1:0] o_quotient
);
    import itrd_pkg::*;

    localparam int STEPS = DIVIDEND_BITS / DIV_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIVIDEND_BITS-1:0] r_quot, n_quot;
    logic [RADIX_W-1:0]       r_rem, n_rem;
    logic [RADIX_W-1:0]       r_div;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;

    // one shared compare/subtract chain, DIV_STEP_BITS bits deep
    always_comb begin
        logic [DIVIDEND_BITS-1:0] q;
        logic [RADIX_W-1:0]       rm;
        logic [RADIX_W:0]         wide;
        q  = r_quot;
        rm = r_rem;
        for (int j = 0; j < DIV_STEP_BITS; j++) begin
            wide = {rm, q[DIVIDEND_BITS-1]};
            q    = {q[DIVIDEND_BITS-2:0], 1'b0};
            if (wide >= {1'b0, r_div}) begin
                wide = wide - {1'b0, r_div};
                q[0] = 1'b1;
            end
            rm = wide[RADIX_W-1:0];
        end

        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(STEPS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = q;
            n_rem  = rm;
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        if (i_req.start) begin
            r_div <= i_req.divisor;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;
    assign o_quotient      = r_quot;

endmodule

// ===== design/integer_to_radix_digits.sv =====
// Top level of the integer to radix digits converter: sequencer, base register,
// output register. Depends on itrd_pkg, itrd_divider and itrd_ram.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall, payload i_value): one transaction
//    carries one unsigned value; only its low VALUE_BITS bits are converted.
//  - Output channel (o_out_valid / i_out_stall): one transaction per digit,
//    o_digit_char is ASCII '0'..'9','A'..'Z', most significant digit first;
//    o_last_digit marks the final digit of the run. Zero gives a single '0'.
//  - Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): writes the base,
//    saturated to 2..36. Reset value 10. Always ready; write only when idle.
// Timing: each digit takes one pass of the shared divider, which resolves four
//  quotient bits per cycle. After the last digit is found, digits come out at
//  one per cycle while the output is not stalled, through the digit RAM's
//  registered read. The input stays stalled until the last digit of a run has
//  entered the output register; worst case is base 2 with a full-width value.
//  A zero value skips the divider.
// Stall: a stalled output holds its payload; the sequencer pauses reading.
//  The last digit of a run may sit in the output register while the next
//  input transaction is already accepted.
// Reset: synchronous, active low; clears the sequencer, output valid, digit
//  count and sets the base to 10. The digit RAM is not cleared.
module integer_to_radix_digits #(
    parameter int VALUE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [itrd_pkg::VALUE_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [itrd_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                        o_last_digit,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [itrd_pkg::RADIX_W-1:0] i_cfg_data
);
    import itrd_pkg::*;

    // bits actually converted, padded up to whole divider steps
    localparam int EFF_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int QW = ((EFF_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [RADIX_W-1:0]  r_radix;
    logic [COUNT_W-1:0]  r_n, n_n;           // digit count of current run
    logic [COUNT_W-1:0]  r_rd_left, n_rd_left;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic                r_pend, n_pend;     // RAM read data valid for output
    logic                r_pend_last, n_pend_last;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_digit_char, n_digit_char;
    logic                r_last_digit, n_last_digit;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic [QW-1:0]       div_dividend;
    logic [QW-1:0]       div_quot;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [RADIX_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [RADIX_W-1:0]  ram_rdata;

    logic                in_acc;
    logic                out_free;
    logic                value_zero;
    logic [COUNT_W-1:0]  n_plus;

    itrd_divider #(
        .DIVIDEND_BITS (QW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .o_rsp      (div_rsp),
        .o_quotient (div_quot)
    );

    // remainders, least significant digit at address 0
    itrd_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign value_zero  = (i_value[EFF_BITS-1:0] == '0);
    assign n_plus      = r_n + COUNT_W'(1);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_rd_left    = r_rd_left;
        n_rd_addr    = r_rd_addr;
        n_pend       = r_pend;
        n_pend_last  = r_pend_last;
        n_out_valid  = r_out_valid;
        n_digit_char = r_digit_char;
        n_last_digit = r_last_digit;

        div_req.start   = 1'b0;
        div_req.divisor = r_radix;
        div_dividend    = div_quot;
        ram_we          = 1'b0;
        ram_waddr       = r_n[ADDR_W-1:0];
        ram_wdata       = div_rsp.remainder;
        ram_re          = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (value_zero) begin
                        // zero: one stored digit, straight to emission
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = '0;
                        n_n       = COUNT_W'(1);
                        n_rd_left = COUNT_W'(1);
                        n_rd_addr = '0;
                        n_state   = ST_EMIT;
                    end else begin
                        div_req.start = 1'b1;
                        div_dividend  = QW'(i_value[EFF_BITS-1:0]);
                        n_n           = '0;
                        n_state       = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    ram_we = 1'b1;
                    n_n    = n_plus;
                    if (div_quot == '0 || n_plus == COUNT_W'(STORE_DEPTH)) begin
                        n_rd_left = n_plus;
                        n_rd_addr = r_n[ADDR_W-1:0];
                        n_state   = ST_EMIT;
                    end else begin
                        div_req.start = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (r_pend && out_free) begin
                    n_out_valid  = 1'b1;
                    n_digit_char = digit_to_char(ram_rdata);
                    n_last_digit = r_pend_last;
                    n_pend       = 1'b0;
                    if (r_pend_last) begin
                        n_state = ST_IDLE;
                    end
                end
                // read ahead so digits leave back to back
                if (r_rd_left != '0 && (!r_pend || out_free)) begin
                    ram_re      = 1'b1;
                    n_rd_addr   = r_rd_addr - ADDR_W'(1);
                    n_rd_left   = r_rd_left - COUNT_W'(1);
                    n_pend      = 1'b1;
                    n_pend_last = (r_rd_left == COUNT_W'(1));
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit_char <= n_digit_char;
        r_last_digit <= n_last_digit;
        r_rd_addr    <= n_rd_addr;
        r_pend_last  <= n_pend_last;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_radix     <= RADIX_RESET;
            r_n         <= '0;
            r_rd_left   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_rd_left   <= n_rd_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radix <= radix_sat(i_cfg_data);
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_digit_char;
    assign o_last_digit = r_last_digit;

    // divider only reports while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ST_DIV)
        else $error("divider done outside division phase");

    // pending RAM data only exists during emission
    a_pend_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_state == ST_EMIT)
        else $error("pending digit outside emission phase");

    // a run never outgrows the digit store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= COUNT_W'(STORE_DEPTH))
        else $error("digit count beyond store depth");

    // base register stays within its legal range
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_radix >= RADIX_MIN && r_radix <= RADIX_MAX)
        else $error("radix out of range");

endmodule
